>>> hw/rtl/tbp_pkg.sv
// Shared types, constants and helpers of the tournament branch predictor.
package tbp_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 2048;
  localparam int unsigned HISTORY_BITS_DEF  = 11;

  typedef logic [1:0] ctr_t;

  localparam ctr_t CTR_STRONG_TAKEN  = 2'd3;
  localparam ctr_t CTR_STRONG_NTAKEN = 2'd0;
  localparam ctr_t CHO_STRONG_GSHARE = 2'd0;
  localparam ctr_t CHO_STRONG_BIMOD  = 2'd3;

  typedef struct packed {
    logic [31:0] branch_address;
    logic        taken;
  } tbp_in_t;

  typedef struct packed {
    logic        final_prediction;
    logic        prediction_correct;
    logic        gshare_prediction;
    logic        bimodal_prediction;
    logic [31:0] correct_total;
  } tbp_out_t;

  typedef struct packed {
    ctr_t bim;
    ctr_t cho;
    ctr_t gsh;
  } tbp_ctrs_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } tbp_state_e;

  function automatic ctr_t train2(ctr_t c, logic up);
    ctr_t r;
    r = c;
    if (up) begin
      if (c != CTR_STRONG_TAKEN) r = c + 2'd1;
    end else begin
      if (c != CTR_STRONG_NTAKEN) r = c - 2'd1;
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/tbp_tables.sv
// Counter memories: bimodal with chooser in one array, gshare in another.
module tbp_tables #(
  parameter int unsigned TABLE_ENTRIES = tbp_pkg::TABLE_ENTRIES_DEF,
  localparam int unsigned IDX_W        = $clog2(TABLE_ENTRIES)
) (
  input  logic              clk_i,
  input  logic [IDX_W-1:0]  rd_bidx_i,
  input  logic [IDX_W-1:0]  rd_gidx_i,
  input  logic              wr_en_i,
  input  logic [IDX_W-1:0]  wr_bidx_i,
  input  logic [IDX_W-1:0]  wr_gidx_i,
  input  tbp_pkg::tbp_ctrs_t wr_data_i,
  output tbp_pkg::tbp_ctrs_t rd_data_o
);
  import tbp_pkg::*;

  logic [3:0] bc_mem [TABLE_ENTRIES];
  ctr_t       gs_mem [TABLE_ENTRIES];

  logic [3:0] bc_rd_q;
  ctr_t       gs_rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      bc_mem[wr_bidx_i] <= {wr_data_i.bim, wr_data_i.cho};
    end
    bc_rd_q <= bc_mem[rd_bidx_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      gs_mem[wr_gidx_i] <= wr_data_i.gsh;
    end
    gs_rd_q <= gs_mem[rd_gidx_i];
  end

  assign rd_data_o.bim = bc_rd_q[3:2];
  assign rd_data_o.cho = bc_rd_q[1:0];
  assign rd_data_o.gsh = gs_rd_q;

endmodule

>>> hw/rtl/tbp_core.sv
// Sequencer: table clearing, index forming, prediction, training and result register.
module tbp_core #(
  parameter int unsigned TABLE_ENTRIES = tbp_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned HISTORY_BITS  = tbp_pkg::HISTORY_BITS_DEF,
  localparam int unsigned IDX_W        = $clog2(TABLE_ENTRIES)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tbp_pkg::tbp_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tbp_pkg::tbp_out_t  out_data_o,
  output logic [IDX_W-1:0]   rd_bidx_o,
  output logic [IDX_W-1:0]   rd_gidx_o,
  output logic               wr_en_o,
  output logic [IDX_W-1:0]   wr_bidx_o,
  output logic [IDX_W-1:0]   wr_gidx_o,
  output tbp_pkg::tbp_ctrs_t wr_data_o,
  input  tbp_pkg::tbp_ctrs_t rd_data_i
);
  import tbp_pkg::*;

  localparam int unsigned XW = (IDX_W > HISTORY_BITS) ? IDX_W : HISTORY_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  tbp_state_e              state_q, state_d;
  logic [IDX_W-1:0]        clr_idx_q, clr_idx_d;
  logic [IDX_W-1:0]        bidx_q, bidx_d;
  logic [IDX_W-1:0]        gidx_q, gidx_d;
  logic                    taken_q, taken_d;
  logic [HISTORY_BITS-1:0] hist_q, hist_d;
  logic [31:0]             correct_q, correct_d;
  logic                    out_valid_q, out_valid_d;
  tbp_out_t                out_q, out_d;

  logic             in_fire;
  logic             upd_go;
  logic [XW-1:0]    bidx_x, hist_x;
  logic [IDX_W-1:0] bidx_in, gidx_in;
  logic             gp, bp, fp, ok, gok, bok;
  tbp_ctrs_t        trained;
  tbp_ctrs_t        clr_word;

  assign in_fire = in_valid_i && !in_stall_o;
  assign upd_go  = !out_valid_q || !out_stall_i;

  assign bidx_in = in_data_i.branch_address[IDX_W-1:0];
  assign bidx_x  = XW'(bidx_in);
  assign hist_x  = XW'(hist_q);
  assign gidx_in = IDX_W'(bidx_x ^ hist_x);

  assign clr_word.bim = CTR_STRONG_TAKEN;
  assign clr_word.cho = CHO_STRONG_GSHARE;
  assign clr_word.gsh = CTR_STRONG_TAKEN;

  always_comb begin
    gp  = rd_data_i.gsh[1];
    bp  = rd_data_i.bim[1];
    fp  = rd_data_i.cho[1] ? bp : gp;
    ok  = (fp == taken_q);
    gok = (gp == taken_q);
    bok = (bp == taken_q);
    trained.bim = train2(rd_data_i.bim, taken_q);
    trained.gsh = train2(rd_data_i.gsh, taken_q);
    trained.cho = rd_data_i.cho;
    if (bok && !gok) begin
      trained.cho = train2(rd_data_i.cho, 1'b1);
    end else if (gok && !bok) begin
      trained.cho = train2(rd_data_i.cho, 1'b0);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_idx_q == LAST_IDX) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (upd_go) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_stall_o  = 1'b1;
    wr_en_o     = 1'b0;
    wr_bidx_o   = bidx_q;
    wr_gidx_o   = gidx_q;
    wr_data_o   = trained;
    rd_bidx_o   = bidx_q;
    rd_gidx_o   = gidx_q;
    clr_idx_d   = clr_idx_q;
    bidx_d      = bidx_q;
    gidx_d      = gidx_q;
    taken_d     = taken_q;
    hist_d      = hist_q;
    correct_d   = correct_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    unique case (state_q)
      ST_CLEAR: begin
        wr_en_o   = 1'b1;
        wr_bidx_o = clr_idx_q;
        wr_gidx_o = clr_idx_q;
        wr_data_o = clr_word;
        clr_idx_d = clr_idx_q + 1'b1;
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        rd_bidx_o  = bidx_in;
        rd_gidx_o  = gidx_in;
        if (in_valid_i) begin
          bidx_d  = bidx_in;
          gidx_d  = gidx_in;
          taken_d = in_data_i.taken;
        end
      end
      ST_UPDATE: begin
        if (upd_go) begin
          wr_en_o   = 1'b1;
          hist_d    = HISTORY_BITS'({hist_q, taken_q});
          if (ok && (correct_q != 32'hFFFF_FFFF)) correct_d = correct_q + 32'd1;
          out_valid_d              = 1'b1;
          out_d.final_prediction   = fp;
          out_d.prediction_correct = ok;
          out_d.gshare_prediction  = gp;
          out_d.bimodal_prediction = bp;
          out_d.correct_total      = correct_d;
        end
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_idx_q   <= '0;
      hist_q      <= '0;
      correct_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      hist_q      <= hist_d;
      correct_q   <= correct_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bidx_q  <= bidx_d;
    gidx_q  <= gidx_d;
    taken_q <= taken_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hw/rtl/tournament_branch_predictor_top.sv
// Tournament branch predictor (gshare and bimodal with per-address chooser), top level.
// After reset the block sweeps every entry of its counter tables, holding
// in_stall_o high, then takes one resolved branch at a time: first the synchronous
// table read, then a step that trains the counters, writes them back and loads the
// result register. Tables are indexed by the low address bits, so TABLE_ENTRIES must
// be a power of two. A pending result does not block acceptance of the next beat; a
// result is only held up while the previous one is still stalled at the output.
module tournament_branch_predictor_top #(
  parameter int unsigned TABLE_ENTRIES = tbp_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned HISTORY_BITS  = tbp_pkg::HISTORY_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tbp_pkg::tbp_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tbp_pkg::tbp_out_t out_data_o
);
  import tbp_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

  logic [IDX_W-1:0] rd_bidx, rd_gidx, wr_bidx, wr_gidx;
  logic             wr_en;
  tbp_ctrs_t        wr_data, rd_data;

  tbp_core #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .HISTORY_BITS (HISTORY_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .rd_bidx_o  (rd_bidx),
    .rd_gidx_o  (rd_gidx),
    .wr_en_o    (wr_en),
    .wr_bidx_o  (wr_bidx),
    .wr_gidx_o  (wr_gidx),
    .wr_data_o  (wr_data),
    .rd_data_i  (rd_data)
  );

  tbp_tables #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_tables (
    .clk_i    (clk_i),
    .rd_bidx_i(rd_bidx),
    .rd_gidx_i(rd_gidx),
    .wr_en_i  (wr_en),
    .wr_bidx_i(wr_bidx),
    .wr_gidx_i(wr_gidx),
    .wr_data_i(wr_data),
    .rd_data_o(rd_data)
  );

endmodule

>>> hw/rtl/tbp_checker.sv
// Port-level assertions for the tournament branch predictor, bound to the top level.
module tbp_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input tbp_pkg::tbp_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input tbp_pkg::tbp_out_t out_data_o
);
  import tbp_pkg::*;

  logic in_fire;
  logic taken_q;

  assign in_fire = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q <= 1'b0;
    end else if (in_fire) begin
      taken_q <= in_data_i.taken;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> in_stall_o)
    else $error("second beat accepted while one is in flight");

  a_correct_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |->
      out_data_o.prediction_correct == (out_data_o.final_prediction == taken_q))
    else $error("correct flag disagrees with accepted outcome");

  a_final_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.final_prediction == out_data_o.gshare_prediction) ||
                    (out_data_o.final_prediction == out_data_o.bimodal_prediction))
    else $error("final prediction matches neither component");

endmodule

bind tournament_branch_predictor_top tbp_checker u_tbp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);
